// ===== design/lvpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvpc_pkg: shared types and constants for the load value predictor
// Request/result payload structs, mode and register codes, FSM states.
// ----------------------------------------------------------------------------
package lvpc_pkg;

  // Default table index width (table depth is 2**INDEX_BITS)
  localparam int unsigned INDEX_BITS_DEF = 10;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned PC_W    = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned CONF_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Predictor modes
  localparam logic [1:0] MODE_LAST       = 2'd0;
  localparam logic [1:0] MODE_LAST_GATED = 2'd1;
  localparam logic [1:0] MODE_STRIDE     = 2'd2;
  localparam logic [1:0] MODE_STRIDE_GATED = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_STRIDE  = 2'd2;

  // Counter width code that selects the two-bit scheme
  localparam logic [1:0] CNT_BITS_TWO = 2'd2;

  // Register reset values
  localparam logic [1:0] MODE_RST     = MODE_LAST_GATED;
  localparam logic [1:0] CNT_BITS_RST = CNT_BITS_TWO;

  // Confidence codes
  localparam logic [CONF_W-1:0] CONF_0 = 2'd0;
  localparam logic [CONF_W-1:0] CONF_1 = 2'd1;
  localparam logic [CONF_W-1:0] CONF_2 = 2'd2;
  localparam logic [CONF_W-1:0] CONF_3 = 2'd3;

  // Input request payload
  typedef struct packed {
    logic [PC_W-1:0]    load_pc;
    logic [VALUE_W-1:0] load_value;
  } in_req_t;

  // Result payload
  typedef struct packed {
    logic [VALUE_W-1:0] predicted_value;
    logic               prediction_hit;
    logic               prediction_used;
    logic [COUNT_W-1:0] hits_used;
    logic [COUNT_W-1:0] predictions_used;
  } out_rsp_t;

  // Control states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

endpackage

// ===== design/lvpc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvpc_ram: generic synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lvpc_ram #(
  parameter int unsigned WIDTH     = 66,
  parameter int unsigned ADDR_BITS = 10
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/load_value_predictor_confidence.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_value_predictor_confidence: last-value / stride load value predictor
// Per-entry last value and confidence in one RAM, global stride, used and
// hit counters.
// ----------------------------------------------------------------------------
// Loads are handled one at a time. The accepting edge raises busy and starts the
// read of the table RAM entry (value and confidence share one word). The entry
// is held through the wait state ST_READ. The next cycle (ST_UPDATE) forms
// the prediction, compares it and writes the entry back. The result strobe
// out_valid is high for one cycle right after that, and a new start may be
// taken at the edge that ends it. A new load is thus not taken until the last
// has passed the registered table read, the wait state and the write-back.
// Results cannot be held off; each shows for exactly one cycle.
// After reset the block clears all 2**INDEX_BITS table entries (1024 at
// the default) with busy high; configuration writes are taken meanwhile.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module load_value_predictor_confidence #(
  parameter int unsigned INDEX_BITS = lvpc_pkg::INDEX_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // request channel
  input  logic                                   start,
  output logic                                   busy,
  input  lvpc_pkg::in_req_t                      in_req,
  // result channel
  output logic                                   out_valid,
  output lvpc_pkg::out_rsp_t                     out_rsp,
  // configuration
  input  logic                                   cfg_we,
  input  logic [lvpc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lvpc_pkg::VALUE_W-1:0]           cfg_wdata
);

  localparam int unsigned ENTRY_W = lvpc_pkg::VALUE_W + lvpc_pkg::CONF_W;
  localparam logic [lvpc_pkg::COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [INDEX_BITS-1:0] LAST_IDX = '1;

  // Confidence gate
  function automatic logic conf_allows(input logic [lvpc_pkg::CONF_W-1:0] c,
                                       input logic two_bit);
    if (two_bit) begin
      return (c == lvpc_pkg::CONF_2) || (c == lvpc_pkg::CONF_3);
    end
    return c == lvpc_pkg::CONF_1;
  endfunction

  // Confidence update
  function automatic logic [lvpc_pkg::CONF_W-1:0] conf_next(
      input logic [lvpc_pkg::CONF_W-1:0] c, input logic hit, input logic two_bit);
    logic [lvpc_pkg::CONF_W-1:0] n;
    n = hit ? lvpc_pkg::CONF_1 : lvpc_pkg::CONF_0;
    if (two_bit) begin
      case (c)
        lvpc_pkg::CONF_0: n = hit ? lvpc_pkg::CONF_1 : lvpc_pkg::CONF_0;
        lvpc_pkg::CONF_3: n = hit ? lvpc_pkg::CONF_3 : lvpc_pkg::CONF_2;
        default:          n = hit ? lvpc_pkg::CONF_3 : lvpc_pkg::CONF_0;
      endcase
    end
    return n;
  endfunction

  // Control and configuration registers
  lvpc_pkg::state_t                  state_r, state_nxt;
  logic [INDEX_BITS-1:0]             clr_idx_r, clr_idx_nxt;
  logic [1:0]                        mode_r;
  logic [1:0]                        cnt_bits_r;
  logic [lvpc_pkg::VALUE_W-1:0]      stride_r, stride_nxt;
  logic [lvpc_pkg::COUNT_W-1:0]      hits_r, hits_nxt;
  logic [lvpc_pkg::COUNT_W-1:0]      used_r, used_nxt;
  logic                              out_valid_r, out_valid_nxt;
  lvpc_pkg::out_rsp_t                out_rsp_r;
  lvpc_pkg::in_req_t                 req_r;

  // RAM port signals
  logic                              ram_we;
  logic [INDEX_BITS-1:0]             ram_waddr;
  logic [ENTRY_W-1:0]                ram_wdata;
  logic                              ram_re;
  logic [ENTRY_W-1:0]                ram_rdata;

  // Datapath signals
  logic                              accept;
  logic [lvpc_pkg::VALUE_W-1:0]      old_value;
  logic [lvpc_pkg::CONF_W-1:0]       old_conf;
  logic [lvpc_pkg::CONF_W-1:0]       new_conf;
  logic [lvpc_pkg::VALUE_W-1:0]      pred;
  logic                              strided, gated, two_bit, hit, used;

  assign accept = start && (state_r == lvpc_pkg::ST_IDLE);

  // Prediction and update from the entry read out of the table
  assign old_value = ram_rdata[lvpc_pkg::VALUE_W-1:0];
  assign old_conf  = ram_rdata[ENTRY_W-1:lvpc_pkg::VALUE_W];
  assign strided   = (mode_r == lvpc_pkg::MODE_STRIDE) ||
                     (mode_r == lvpc_pkg::MODE_STRIDE_GATED);
  assign gated     = (mode_r == lvpc_pkg::MODE_LAST_GATED) ||
                     (mode_r == lvpc_pkg::MODE_STRIDE_GATED);
  assign two_bit   = (cnt_bits_r == lvpc_pkg::CNT_BITS_TWO);
  assign pred      = strided ? old_value + stride_r : old_value;
  assign hit       = (pred == req_r.load_value);
  assign used      = gated ? conf_allows(old_conf, two_bit) : 1'b1;

  always_comb begin
    case (mode_r)
      lvpc_pkg::MODE_LAST:   new_conf = hit ? lvpc_pkg::CONF_1 : lvpc_pkg::CONF_0;
      lvpc_pkg::MODE_STRIDE: new_conf = old_conf;
      default:               new_conf = conf_next(old_conf, hit, two_bit);
    endcase
  end

  // Next state, RAM control and datapath next values
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    stride_nxt    = stride_r;
    hits_nxt      = hits_r;
    used_nxt      = used_r;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = req_r.load_pc[INDEX_BITS-1:0];
    ram_wdata     = {new_conf, req_r.load_value};
    ram_re        = accept;
    case (state_r)
      lvpc_pkg::ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        ram_wdata   = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = lvpc_pkg::ST_IDLE;
        end
      end
      lvpc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = lvpc_pkg::ST_READ;
        end
      end
      lvpc_pkg::ST_READ: begin
        state_nxt = lvpc_pkg::ST_UPDATE;
      end
      lvpc_pkg::ST_UPDATE: begin
        ram_we        = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = lvpc_pkg::ST_IDLE;
        if (strided && !hit) begin
          stride_nxt = req_r.load_value - old_value;
        end
        if (used) begin
          if (used_r != COUNT_MAX) begin
            used_nxt = used_r + 1'b1;
          end
          if (hit && (hits_r != COUNT_MAX)) begin
            hits_nxt = hits_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = lvpc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lvpc_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      hits_r      <= '0;
      used_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      hits_r      <= hits_nxt;
      used_r      <= used_nxt;
    end
  end

  // Configuration registers and global stride; an initial_stride write
  // loads the global stride directly (its reset value is zero)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= lvpc_pkg::MODE_RST;
      cnt_bits_r <= lvpc_pkg::CNT_BITS_RST;
      stride_r   <= '0;
    end else begin
      if (cfg_we && (cfg_index == lvpc_pkg::CFG_INIT_STRIDE)) begin
        stride_r <= cfg_wdata;
      end else begin
        stride_r <= stride_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          lvpc_pkg::CFG_MODE:         mode_r     <= cfg_wdata[1:0];
          lvpc_pkg::CFG_COUNTER_BITS: cnt_bits_r <= cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (state_r == lvpc_pkg::ST_UPDATE) begin
      out_rsp_r.predicted_value  <= pred;
      out_rsp_r.prediction_hit   <= hit;
      out_rsp_r.prediction_used  <= used;
      out_rsp_r.hits_used        <= hits_nxt;
      out_rsp_r.predictions_used <= used_nxt;
    end
  end

  // Table RAM: {confidence, last value} per entry
  lvpc_ram #(
    .WIDTH     (ENTRY_W),
    .ADDR_BITS (INDEX_BITS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_req.load_pc[INDEX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != lvpc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
